### design/fpsc_pkg.sv
package fpsc_pkg;

  localparam int AngleW = 24;
  localparam int MagW   = 24;
  localparam int DegW   = 25;
  localparam int ProdW  = 31;
  localparam int QuotW  = 20;
  localparam int RemW   = 9;
  localparam int FoldW  = 7;
  localparam int IdxW   = 5;
  localparam int LutW   = 10;
  localparam int ValW   = 11;

  // mrad -> deg: floor(mag * 180 / 3142) as (mag * 180 * RecipPi) >> PiShift
  localparam logic [7:0]  MradScale = 8'd180;
  localparam logic [31:0] RecipPi   = 32'd2799520377;
  localparam int          PiShift   = 43;

  // floor(d / 360) as (d * Recip360) >> FullShift
  localparam logic [24:0] Recip360  = 25'd23860930;
  localparam int          FullShift = 33;

  localparam logic [8:0] DegFull  = 9'd360;
  localparam logic [8:0] DegHalf  = 9'd180;
  localparam logic [8:0] DegRight = 9'd90;
  localparam logic [8:0] DegThree = 9'd270;
  localparam logic [1:0] StepDeg  = 2'd3;

  // floor(x / 3) for x < 128 as (x * 171) >> 9
  localparam logic [7:0] RecipStep = 8'd171;
  localparam int         StepShift = 9;
  // floor(x / 3) for x < 4096 as (x * 2731) >> 13
  localparam logic [11:0] RecipFrac = 12'd2731;
  localparam int          FracShift = 13;

  localparam logic signed [ValW-1:0] ValMax = 11'sd1000;
  localparam logic signed [ValW-1:0] ValMin = -11'sd1000;

  typedef struct packed {
    logic                   valid;
    logic signed [DegW-1:0] deg;
  } deg_xfer_t;

  typedef struct packed {
    logic             valid;
    logic             zero;
    logic             neg;
    logic [FoldW-1:0] ang;
  } fold_xfer_t;

  // cosine * 1000 at 3-degree steps, 0 to 90 degrees
  function automatic logic [LutW-1:0] cos_lut(input logic [IdxW-1:0] idx);
    logic [LutW-1:0] v;
    unique case (idx)
      5'd0:  v = 10'd1000;
      5'd1:  v = 10'd999;
      5'd2:  v = 10'd995;
      5'd3:  v = 10'd988;
      5'd4:  v = 10'd978;
      5'd5:  v = 10'd966;
      5'd6:  v = 10'd951;
      5'd7:  v = 10'd934;
      5'd8:  v = 10'd914;
      5'd9:  v = 10'd891;
      5'd10: v = 10'd866;
      5'd11: v = 10'd839;
      5'd12: v = 10'd809;
      5'd13: v = 10'd777;
      5'd14: v = 10'd743;
      5'd15: v = 10'd707;
      5'd16: v = 10'd669;
      5'd17: v = 10'd629;
      5'd18: v = 10'd588;
      5'd19: v = 10'd545;
      5'd20: v = 10'd500;
      5'd21: v = 10'd454;
      5'd22: v = 10'd407;
      5'd23: v = 10'd358;
      5'd24: v = 10'd309;
      5'd25: v = 10'd259;
      5'd26: v = 10'd208;
      5'd27: v = 10'd156;
      5'd28: v = 10'd105;
      5'd29: v = 10'd52;
      5'd30: v = 10'd0;
      default: v = 10'd0;
    endcase
    return v;
  endfunction

endpackage

### design/fpsc_deg_conv.sv
module fpsc_deg_conv (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              ce,
  input  logic                              in_valid,
  input  logic                              operation,
  input  logic                              angle_unit,
  input  logic signed [fpsc_pkg::AngleW-1:0] angle,
  output fpsc_pkg::deg_xfer_t               deg_out
);
  import fpsc_pkg::*;

  // stage 1: sign and magnitude
  logic            v1, op1, unit1, neg1;
  logic [MagW-1:0] mag1;
  // stage 2: scale by 180
  logic             v2, op2, unit2, neg2;
  logic [MagW-1:0]  mag2;
  logic [ProdW-1:0] prod2;
  // stage 3: reciprocal product
  logic            v3, op3, unit3, neg3;
  logic [MagW-1:0] mag3;
  logic [62:0]     prod3;
  // stage 4: signed degrees
  logic                   v4;
  logic signed [DegW-1:0] deg4;

  logic [QuotW-1:0]       quot;
  logic [MagW-1:0]        mag_sel;
  logic signed [DegW-1:0] sdeg;
  logic signed [DegW-1:0] deg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (ce) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      op1   <= operation;
      unit1 <= angle_unit;
      neg1  <= angle[AngleW-1];
      mag1  <= angle[AngleW-1] ? MagW'(~angle + 1'b1) : MagW'(angle);

      op2   <= op1;
      unit2 <= unit1;
      neg2  <= neg1;
      mag2  <= mag1;
      prod2 <= ProdW'(ProdW'(mag1) * ProdW'(MradScale));

      op3   <= op2;
      unit3 <= unit2;
      neg3  <= neg2;
      mag3  <= mag2;
      prod3 <= 63'(prod2) * 63'(RecipPi);

      deg4 <= deg_next;
    end
  end

  always_comb begin
    quot     = prod3[PiShift+QuotW-1:PiShift];
    mag_sel  = unit3 ? MagW'(quot) : mag3;
    sdeg     = neg3 ? -$signed({1'b0, mag_sel}) : $signed({1'b0, mag_sel});
    deg_next = op3 ? DegW'(sdeg - DegW'(DegRight)) : sdeg;
  end

  assign deg_out = '{valid: v4, deg: deg4};

endmodule

### design/fpsc_reduce.sv
module fpsc_reduce (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ce,
  input  fpsc_pkg::deg_xfer_t  deg_in,
  output fpsc_pkg::fold_xfer_t fold_out
);
  import fpsc_pkg::*;

  logic            v1, v2, v3, v4;
  logic [MagW-1:0] d1, d2;
  logic [48:0]     p2;
  logic [RemW-1:0] r3;
  logic             zero4;
  logic             neg4;
  logic [FoldW-1:0] ang4;

  logic [15:0]      q;
  logic [24:0]      qm;
  logic [RemW-1:0]  r_next;
  logic [7:0]       t;
  logic             neg_next;
  logic             zero_next;
  logic [FoldW-1:0] f_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (ce) begin
      v1 <= deg_in.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      d1 <= deg_in.deg[DegW-1] ? MagW'(-deg_in.deg) : MagW'(deg_in.deg);
      d2 <= d1;
      p2 <= 49'(d1) * 49'(Recip360);
      r3 <= r_next;
      zero4 <= zero_next;
      neg4  <= neg_next;
      ang4  <= f_next;
    end
  end

  always_comb begin
    q      = p2[FullShift+15:FullShift];
    qm     = 25'(q) * 25'(DegFull);
    r_next = RemW'(25'(d2) - qm);
  end

  // fold 0..359 onto 0..90 with a sign; right angles come out as exact zero
  always_comb begin
    zero_next = (r3 == DegRight) || (r3 == DegThree);
    if (r3 >= DegHalf) begin
      t        = 8'(r3 - DegHalf);
      neg_next = 1'b1;
    end else begin
      t        = 8'(r3);
      neg_next = 1'b0;
    end
    if (t >= 8'(DegRight)) begin
      f_next   = FoldW'(8'(DegHalf) - t);
      neg_next = ~neg_next;
    end else begin
      f_next = FoldW'(t);
    end
  end

  assign fold_out = '{valid: v4, zero: zero4, neg: neg4, ang: ang4};

endmodule

### design/fpsc_interp.sv
module fpsc_interp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               ce,
  input  fpsc_pkg::fold_xfer_t               fold_in,
  output logic                               out_valid,
  output logic signed [fpsc_pkg::ValW-1:0]   value
);
  import fpsc_pkg::*;

  logic            v1, zero1, neg1;
  logic [1:0]      rem1;
  logic [LutW-1:0] lo1, hi1;

  logic [14:0]            idx_prod;
  logic [IdxW-1:0]        idx;
  logic [1:0]             rem;
  logic [LutW-1:0]        dn;
  logic [11:0]            frac;
  logic [23:0]            frac_prod;
  logic [LutW-1:0]        frac_div;
  logic [LutW-1:0]        mag;
  logic signed [ValW-1:0] value_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      v1        <= fold_in.valid;
      out_valid <= v1;
    end
  end

  always_comb begin
    idx_prod = 15'(fold_in.ang) * 15'(RecipStep);
    idx      = IdxW'(idx_prod >> StepShift);
    rem      = 2'(7'(fold_in.ang) - 7'(idx) * 7'(StepDeg));
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      zero1 <= fold_in.zero;
      neg1  <= fold_in.neg;
      rem1  <= rem;
      lo1   <= cos_lut(idx);
      hi1   <= cos_lut(IdxW'(idx + 1'b1));
      value <= value_next;
    end
  end

  // table falls monotonically, so the step truncates toward zero as lo - floor(...)
  always_comb begin
    dn        = lo1 - hi1;
    frac      = 12'(dn) * 12'(rem1);
    frac_prod = 24'(frac) * 24'(RecipFrac);
    frac_div  = LutW'(frac_prod >> FracShift);
    mag       = lo1 - frac_div;
    if (zero1) begin
      value_next = '0;
    end else if (neg1) begin
      value_next = -$signed({1'b0, mag});
    end else begin
      value_next = $signed({1'b0, mag});
    end
  end

endmodule

### design/fixed_point_sine_cosine_top.sv
// Fixed-point sine / cosine, result scaled by 1000.
//
// Input stream (s_axis_*): one angle per transaction. tdata carries the
// signed 24-bit angle, tuser says whether it is degrees or milliradians
// and whether the cosine or the sine is wanted. Milliradians are turned
// into whole degrees (truncated toward zero) before the lookup.
// Output stream (m_axis_*): one transaction per input, tdata carries the
// signed 11-bit result in -1000..1000.
//
// Throughput: one transaction per cycle unless m_axis_tready stalls the
// output. Ten register stages lie between input and output: the accepting
// edge loads the first stage and m_axis_tvalid comes from the last.
// Four stages for the unit conversion (magnitude, x180, reciprocal multiply,
// sign/offset), four for the modulo-360 reduction and quadrant fold, two for
// the table lookup and interpolation. The output register is the last stage.
//
// Reset empties the pipeline; nothing else is stored. When the receiver
// holds m_axis_tready low with a result waiting, the whole pipeline
// freezes and s_axis_tready drops in the same cycle; nothing is lost.
module fixed_point_sine_cosine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] angle
  input  logic [1:0]  s_axis_tuser,   // [0] operation, [1] angle_unit
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [10:0] value, [15:11] zero
);
  import fpsc_pkg::*;

  logic                   ce;
  deg_xfer_t              deg_x;
  fold_xfer_t             fold_x;
  logic signed [ValW-1:0] value;

  // advance everything unless a finished result is stuck at the output
  assign ce            = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = ce;

  fpsc_deg_conv u_deg_conv (
    .clk        (clk),
    .rst        (rst),
    .ce         (ce),
    .in_valid   (s_axis_tvalid),
    .operation  (s_axis_tuser[0]),
    .angle_unit (s_axis_tuser[1]),
    .angle      ($signed(s_axis_tdata[AngleW-1:0])),
    .deg_out    (deg_x)
  );

  fpsc_reduce u_reduce (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .deg_in   (deg_x),
    .fold_out (fold_x)
  );

  fpsc_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .fold_in   (fold_x),
    .out_valid (m_axis_tvalid),
    .value     (value)
  );

  assign m_axis_tdata = {5'b0, value};

endmodule

### design/fpsc_checker.sv
module fpsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  import fpsc_pkg::*;

  // a stalled result holds until taken
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transaction dropped or changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $signed(m_axis_tdata[ValW-1:0]) <= ValMax
                   && $signed(m_axis_tdata[ValW-1:0]) >= ValMin
                   && m_axis_tdata[15:ValW] == '0)
    else $error("result out of range");

  // an idle input with s_axis_tready high leaves the output idle after the pipeline depth
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tvalid && s_axis_tready ##1 !s_axis_tvalid && s_axis_tready
    ##1 !s_axis_tvalid && s_axis_tready ##1 !s_axis_tvalid && s_axis_tready
    ##1 !s_axis_tvalid && s_axis_tready ##1 !s_axis_tvalid && s_axis_tready
    ##1 !s_axis_tvalid && s_axis_tready ##1 !s_axis_tvalid && s_axis_tready
    ##1 !s_axis_tvalid && s_axis_tready ##1 !s_axis_tvalid && s_axis_tready
    |=> !m_axis_tvalid)
    else $error("result without an input transaction");

endmodule

bind fixed_point_sine_cosine_top fpsc_checker u_fpsc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
